// File: design/vlfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlfp_pkg
// Shared types and codes of the variable-length frame parser.
// ----------------------------------------------------------------------------
package vlfp_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_START_MARK = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_MARK   = 1'b1;

  localparam logic [7:0] START_MARK_RST = 8'd104;
  localparam logic [7:0] END_MARK_RST   = 8'd22;

  localparam logic [3:0] ROLE_IGNORED  = 4'd0;
  localparam logic [3:0] ROLE_START    = 4'd1;
  localparam logic [3:0] ROLE_LENGTH   = 4'd2;
  localparam logic [3:0] ROLE_LENCOPY  = 4'd3;
  localparam logic [3:0] ROLE_START2   = 4'd4;
  localparam logic [3:0] ROLE_CONTROL  = 4'd5;
  localparam logic [3:0] ROLE_ADDRESS  = 4'd6;
  localparam logic [3:0] ROLE_CI       = 4'd7;
  localparam logic [3:0] ROLE_USER     = 4'd8;
  localparam logic [3:0] ROLE_CHECKSUM = 4'd9;
  localparam logic [3:0] ROLE_END      = 4'd10;

  localparam logic [2:0] ST_RUNNING     = 3'd0;
  localparam logic [2:0] ST_FRAME_OK    = 3'd1;
  localparam logic [2:0] ST_BAD_START   = 3'd2;
  localparam logic [2:0] ST_LEN_MISM    = 3'd3;
  localparam logic [2:0] ST_BAD_START2  = 3'd4;
  localparam logic [2:0] ST_BAD_CSUM    = 3'd5;
  localparam logic [2:0] ST_BAD_END     = 3'd6;

  typedef struct packed {
    logic [3:0] byte_role;
    logic [7:0] data_byte;
    logic [7:0] data_index;
    logic [2:0] status;
    logic [7:0] control_field;
    logic [3:0] telegram_number;
    logic [7:0] address_field;
    logic [7:0] ci_field;
    logic [7:0] user_length;
  } result_t;

  function automatic logic [7:0] user_len_of(input logic [7:0] len);
    return (len >= 8'd3) ? 8'(len - 8'd3) : 8'd0;
  endfunction

endpackage
`default_nettype wire

// File: design/vlfp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlfp_rx_if / vlfp_res_if
// Valid/ready channels: received bytes in, per-byte results out.
// ----------------------------------------------------------------------------
interface vlfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       burst_first;

  modport source (output valid, output rx_byte, output burst_first, input ready);
  modport sink   (input valid, input rx_byte, input burst_first, output ready);
endinterface

interface vlfp_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] byte_role;
  logic [7:0] data_byte;
  logic [7:0] data_index;
  logic [2:0] status;
  logic [7:0] control_field;
  logic [3:0] telegram_number;
  logic [7:0] address_field;
  logic [7:0] ci_field;
  logic [7:0] user_length;

  modport source (
    output valid, output byte_role, output data_byte, output data_index,
    output status, output control_field, output telegram_number,
    output address_field, output ci_field, output user_length, input ready
  );
  modport sink (
    input valid, input byte_role, input data_byte, input data_index,
    input status, input control_field, input telegram_number,
    input address_field, input ci_field, input user_length, output ready
  );
endinterface
`default_nettype wire

// File: design/vlfp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlfp_parser
// Frame state machine: classifies each accepted byte and updates the frame
// state; holds the start/end mark registers.
// ----------------------------------------------------------------------------
module vlfp_parser (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [vlfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vlfp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           accept,
  input  wire logic [7:0]                     rx_byte,
  input  wire logic                           burst_first,
  output vlfp_pkg::result_t                   result
);
  import vlfp_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_LEN, PH_LENCOPY, PH_START2, PH_CTRL,
    PH_ADDR, PH_CI, PH_USER, PH_CSUM, PH_END
  } phase_t;

  phase_t     phase, phase_next;
  logic [7:0] start_mark, end_mark;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] saved_control, saved_control_next;
  logic [7:0] saved_address, saved_address_next;
  logic [7:0] saved_ci, saved_ci_next;

  always_comb begin
    phase_next         = phase;
    frame_length_next  = frame_length;
    bytes_left_next    = bytes_left;
    running_sum_next   = running_sum;
    saved_control_next = saved_control;
    saved_address_next = saved_address;
    saved_ci_next      = saved_ci;
    result             = '0;
    if (burst_first) begin
      frame_length_next  = '0;
      bytes_left_next    = '0;
      running_sum_next   = '0;
      saved_control_next = '0;
      saved_address_next = '0;
      saved_ci_next      = '0;
      result.byte_role   = ROLE_START;
      if (rx_byte != start_mark) begin
        result.status = ST_BAD_START;
        phase_next    = PH_IDLE;
      end else begin
        phase_next = PH_LEN;
      end
    end else begin
      case (phase)
        PH_LEN: begin
          result.byte_role  = ROLE_LENGTH;
          frame_length_next = rx_byte;
          phase_next        = PH_LENCOPY;
        end
        PH_LENCOPY: begin
          result.byte_role = ROLE_LENCOPY;
          if (rx_byte != frame_length) begin
            result.status = ST_LEN_MISM;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_START2;
          end
        end
        PH_START2: begin
          result.byte_role = ROLE_START2;
          if (rx_byte != start_mark) begin
            result.status = ST_BAD_START2;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_CTRL;
          end
        end
        PH_CTRL: begin
          result.byte_role   = ROLE_CONTROL;
          saved_control_next = rx_byte;
          running_sum_next   = rx_byte;
          phase_next         = PH_ADDR;
        end
        PH_ADDR: begin
          result.byte_role   = ROLE_ADDRESS;
          saved_address_next = rx_byte;
          running_sum_next   = 8'(running_sum + rx_byte);
          phase_next         = PH_CI;
        end
        PH_CI: begin
          result.byte_role = ROLE_CI;
          saved_ci_next    = rx_byte;
          running_sum_next = 8'(running_sum + rx_byte);
          bytes_left_next  = user_len_of(frame_length);
          phase_next       = (bytes_left_next != '0) ? PH_USER : PH_CSUM;
        end
        PH_USER: begin
          result.byte_role  = ROLE_USER;
          result.data_byte  = rx_byte;
          result.data_index = 8'(user_len_of(frame_length) - bytes_left);
          running_sum_next  = 8'(running_sum + rx_byte);
          if (bytes_left != '0) begin
            bytes_left_next = 8'(bytes_left - 8'd1);
          end
          if (bytes_left_next == '0) begin
            phase_next = PH_CSUM;
          end
        end
        PH_CSUM: begin
          result.byte_role = ROLE_CHECKSUM;
          if (rx_byte != running_sum) begin
            result.status = ST_BAD_CSUM;
            phase_next    = PH_IDLE;
          end else begin
            phase_next = PH_END;
          end
        end
        PH_END: begin
          result.byte_role = ROLE_END;
          result.status    = (rx_byte != end_mark) ? ST_BAD_END : ST_FRAME_OK;
          phase_next       = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
    if (result.status != ST_RUNNING) begin
      result.control_field   = saved_control_next;
      result.telegram_number = saved_control_next[7:4];
      result.address_field   = saved_address_next;
      result.ci_field        = saved_ci_next;
      result.user_length     = user_len_of(frame_length_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      start_mark    <= START_MARK_RST;
      end_mark      <= END_MARK_RST;
      frame_length  <= '0;
      bytes_left    <= '0;
      running_sum   <= '0;
      saved_control <= '0;
      saved_address <= '0;
      saved_ci      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_MARK: start_mark <= cfg_data[7:0];
          CFG_END_MARK:   end_mark   <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (accept) begin
        phase         <= phase_next;
        frame_length  <= frame_length_next;
        bytes_left    <= bytes_left_next;
        running_sum   <= running_sum_next;
        saved_control <= saved_control_next;
        saved_address <= saved_address_next;
        saved_ci      <= saved_ci_next;
      end
    end
  end

  a_first_is_start: assert property (@(posedge clk) disable iff (rst)
    accept && burst_first |-> result.byte_role == ROLE_START)
    else $error("burst start beat not classified as start mark");

  a_idle_ignores: assert property (@(posedge clk) disable iff (rst)
    accept && !burst_first && phase == PH_IDLE |-> result == '0)
    else $error("beat while idle produced a non-empty result");

  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    accept && result.status != ST_RUNNING |=> phase == PH_IDLE)
    else $error("frame outcome reported but parser not idle");

  a_data_only_user: assert property (@(posedge clk) disable iff (rst)
    result.byte_role != ROLE_USER |-> result.data_byte == '0 && result.data_index == '0)
    else $error("data byte on a non-user beat");

endmodule
`default_nettype wire

// File: design/vlfp_out_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vlfp_out_buf
// Result register with a skid entry; decouples ready from the sink.
// ----------------------------------------------------------------------------
module vlfp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire vlfp_pkg::result_t push_data,
  output logic                   push_ready,
  vlfp_res_if.source             res_chan
);
  import vlfp_pkg::*;

  logic    out_valid, skid_valid;
  result_t out_data, skid_data;
  logic    pop;

  assign pop        = out_valid && res_chan.ready;
  assign push_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!out_valid || pop) begin
        if (skid_valid) begin
          out_valid  <= 1'b1;
          out_data   <= skid_data;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= push;
          out_data  <= push_data;
        end
      end else if (push) begin
        skid_valid <= 1'b1;
        skid_data  <= push_data;
      end
    end
  end

  assign res_chan.valid           = out_valid;
  assign res_chan.byte_role       = out_data.byte_role;
  assign res_chan.data_byte       = out_data.data_byte;
  assign res_chan.data_index      = out_data.data_index;
  assign res_chan.status          = out_data.status;
  assign res_chan.control_field   = out_data.control_field;
  assign res_chan.telegram_number = out_data.telegram_number;
  assign res_chan.address_field   = out_data.address_field;
  assign res_chan.ci_field        = out_data.ci_field;
  assign res_chan.user_length     = out_data.user_length;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while result register empty");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("beat pushed into full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop |=> !skid_valid && out_valid && out_data == $past(skid_data))
    else $error("skid entry not moved to result register");

endmodule
`default_nettype wire

// File: design/variable_length_frame_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// variable_length_frame_parser_core
// Parses variable-length FT1.2-style frames one received byte per beat and
// emits one classified result per byte.
//
//   channel    dir   handshake        payload
//   rx_chan    in    valid/ready      rx_byte, burst_first
//   res_chan   out   valid/ready      role, user byte/index, status, header
//   cfg        in    cfg_we           cfg_index, cfg_data (start/end mark)
//
// One beat per cycle while rx_chan.ready is high; a result is registered
// when its byte is taken. The frame state updates in the accept cycle, so
// throughput is set only by the result register and its skid entry.
// rst is synchronous: parser idle, marks back to 0x68 / 0x16, buffer empty.
// A stalled sink fills the skid entry; rx_chan.ready then drops.
// ----------------------------------------------------------------------------
module variable_length_frame_parser_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [vlfp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [vlfp_pkg::CFG_DATA_W-1:0] cfg_data,
  vlfp_rx_if.sink                             rx_chan,
  vlfp_res_if.source                          res_chan
);
  import vlfp_pkg::*;

  logic    accept;
  logic    push_ready;
  result_t result;

  assign rx_chan.ready = push_ready;
  assign accept        = rx_chan.valid && push_ready;

  vlfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .rx_byte     (rx_chan.rx_byte),
    .burst_first (rx_chan.burst_first),
    .result      (result)
  );

  vlfp_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_data  (result),
    .push_ready (push_ready),
    .res_chan   (res_chan)
  );

endmodule
`default_nettype wire
